[rtl/core/cv2d_pkg.sv]
// ----------------------------------------------------------------------------
// cv2d_pkg
// Shared constants and types for the streaming valid-mode 2d convolution core.
// ----------------------------------------------------------------------------
package cv2d_pkg;

    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_BITS     = 11;
    localparam int KCFG_BITS    = 3;
    localparam int IDX_BITS     = 6;
    localparam int IN_SMP_BITS  = 16;
    localparam int SUM_BITS     = 37;
    localparam int POS_BITS     = 10;
    localparam int ROW_LIMIT    = 1024;

    localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_KERNEL = 2'd2;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    // result tag travelling alongside the multiply-accumulate pipeline
    typedef struct packed {
        logic                res;
        logic [POS_BITS-1:0] row;
        logic [POS_BITS-1:0] col;
        logic                last;
    } res_tag_t;

    typedef struct packed {
        logic                en;
        logic [IDX_BITS-1:0] idx;
    } coef_wr_t;

endpackage

[rtl/core/cv2d_ram.sv]
// ----------------------------------------------------------------------------
// cv2d_ram
// Generic simple dual-port ram, one write port, one registered read port.
// ----------------------------------------------------------------------------
module cv2d_ram #(
    parameter int W = 16,
    parameter int D = 1024
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [$clog2(D)-1:0] waddr,
    input  logic [W-1:0]         wdata,
    input  logic                 re,
    input  logic [$clog2(D)-1:0] raddr,
    output logic [W-1:0]         rdata
);

    logic [W-1:0] mem [D];
    logic [W-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/cv2d_mac.sv]
// ----------------------------------------------------------------------------
// cv2d_mac
// Coefficient store and pipelined multiply / adder tree over the window.
// ----------------------------------------------------------------------------
module cv2d_mac #(
    parameter int MK = 7,
    parameter int SB = 16,
    parameter int KW = 3
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      adv,
    input  logic [KW-1:0]             kv,
    input  logic signed [SB-1:0]      win [MK][MK],
    input  logic                      in_valid,
    input  cv2d_pkg::res_tag_t        in_tag,
    input  cv2d_pkg::coef_wr_t        coef_wr,
    input  logic signed [SB-1:0]      coef_val,
    output logic                      out_valid,
    output cv2d_pkg::res_tag_t        out_tag,
    output logic [cv2d_pkg::SUM_BITS-1:0] out_sum
);
    import cv2d_pkg::*;

    localparam int NC = MK * MK;
    localparam int PW = 2 * SB;
    localparam int KB = $clog2(MK) + 1;
    localparam int RW = PW + KB;
    localparam int TW = RW + KB;

    logic signed [SB-1:0] coef_reg [NC];
    logic signed [SB-1:0] csel [MK][MK];
    logic signed [PW-1:0] prod_reg [MK][MK];
    logic signed [RW-1:0] rsum_next [MK];
    logic signed [RW-1:0] rsum_reg [MK];
    logic signed [TW-1:0] tot_next;
    logic signed [TW-1:0] tot_reg;
    logic [TW+SUM_BITS-1:0] tot_pad;
    logic     va_reg, vb_reg, vc_reg;
    res_tag_t ta_reg, tb_reg, tc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NC; i++) begin
                coef_reg[i] <= '0;
            end
        end else if (adv && coef_wr.en) begin
            for (int i = 0; i < NC; i++) begin
                if (32'(coef_wr.idx) == i) begin
                    coef_reg[i] <= coef_val;
                end
            end
        end
    end

    // coefficient for each window place under the active kernel size
    always_comb begin
        for (int m = 0; m < MK; m++) begin
            for (int n = 0; n < MK; n++) begin
                csel[m][n] = '0;
                for (int kk = 1; kk <= MK; kk++) begin
                    if (32'(kv) == kk && m < kk && n < kk) begin
                        csel[m][n] = coef_reg[m * kk + n];
                    end
                end
            end
        end
    end

    always_comb begin
        for (int m = 0; m < MK; m++) begin
            rsum_next[m] = '0;
            for (int n = 0; n < MK; n++) begin
                rsum_next[m] = rsum_next[m] + RW'(prod_reg[m][n]);
            end
        end
        tot_next = '0;
        for (int m = 0; m < MK; m++) begin
            tot_next = tot_next + TW'(rsum_reg[m]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int m = 0; m < MK; m++) begin
                for (int n = 0; n < MK; n++) begin
                    prod_reg[m][n] <= win[m][n] * csel[m][n];
                end
                rsum_reg[m] <= rsum_next[m];
            end
            tot_reg <= tot_next;
            ta_reg  <= in_tag;
            tb_reg  <= ta_reg;
            tc_reg  <= tb_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end else if (adv) begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    assign tot_pad   = {{SUM_BITS{tot_reg[TW-1]}}, tot_reg};
    assign out_sum   = tot_pad[SUM_BITS-1:0];
    assign out_valid = vc_reg;
    assign out_tag   = tc_reg;

    a_res_has_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (!adv && vc_reg) |=> vc_reg) else $error("mac output lost while stalled");

endmodule

[rtl/core/valid_conv2d_stream_core.sv]
// ----------------------------------------------------------------------------
// valid_conv2d_stream_core
// Valid-mode 2d convolution of a raster pixel stream, exact integer sum.
// ----------------------------------------------------------------------------
// Input beats on s_: s_tuser selects load (0) or pixel (1). A load writes one
// coefficient at a row-major index and is only taken between frames (both
// position counters at zero). Pixels arrive in raster order.
// Output beats on m_: one per window position fully inside the image, with
// the sum, output row and column; m_tlast marks the frame's final result.
// The cfg channel writes width, height and kernel size; any write to one of
// them restarts the frame. cfg_ready is always high.
// Throughput: one beat per cycle, but when the receiver stalls the whole
// pipeline holds and s_tready drops; a finished result waits in the output
// register. The line store is one ram read at the pixel's column, written
// back from p1; same-column back-to-back pixels (width one) are served by a
// forwarding register. An accepted pixel passes p1, p2, the mac's product,
// row-sum and total registers and the output register. Reset clears the
// coefficients, counters and pipeline valids; the line store is not cleared.
// ----------------------------------------------------------------------------
module valid_conv2d_stream_core #(
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_KERNEL  = 7,
    parameter int SAMPLE_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // coeff_index[5:0], sample_value[21:6], zero pad
    input  logic        s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // conv_sum[36:0], out_row[46:37], out_col[56:47], zero pad
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [cv2d_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [cv2d_pkg::CFG_BITS-1:0]     cfg_data
);
    import cv2d_pkg::*;

    localparam int MK = MAX_KERNEL;
    localparam int SB = SAMPLE_BITS;
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int KW = $clog2(MAX_KERNEL + 1);
    localparam int LR = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;
    localparam int NC = MAX_KERNEL * MAX_KERNEL;

    typedef struct packed {
        logic                valid;
        logic                pix;
        logic                ld;
        logic [IDX_BITS-1:0] idx;
        logic [SB-1:0]       val;
        logic [CW-1:0]       col;
        res_tag_t            tag;
    } stage_t;

    logic [CFG_BITS-1:0]  width_reg, height_reg;
    logic [KCFG_BITS-1:0] kernel_reg;
    logic [CW-1:0]        col_reg, col_next;
    logic [POS_BITS-1:0]  row_reg, row_next;
    logic [WW-1:0]        wv;
    logic [CFG_BITS-1:0]  hv;
    logic [KW-1:0]        kv, k1;
    logic                 adv, acc, acc_pix, cfg_wr;
    logic [SB+15:0]       s_pad;
    logic [SB-1:0]        s_val;
    stage_t               p1_reg, p2_reg, p1_next;
    logic [LR*SB-1:0]     ram_q, line_rd, line_wd, fwd_data_reg;
    logic                 fwd_reg;
    logic signed [SB-1:0] old_ln [LR];
    logic signed [SB-1:0] newcol [MK];
    logic signed [SB-1:0] win_reg [MK][MK];
    logic                 mac_valid;
    res_tag_t             mac_tag;
    logic [SUM_BITS-1:0]  mac_sum;
    coef_wr_t             coef_wr;
    logic                 m_tvalid_reg;
    logic [SUM_BITS-1:0]  sum_reg;
    res_tag_t             otag_reg;

    // clamped register values
    always_comb begin
        if (width_reg == '0) begin
            wv = WW'(1);
        end else if (32'(width_reg) > MAX_WIDTH) begin
            wv = WW'(MAX_WIDTH);
        end else begin
            wv = WW'(width_reg);
        end
        if (height_reg == '0) begin
            hv = CFG_BITS'(1);
        end else if (32'(height_reg) > ROW_LIMIT) begin
            hv = CFG_BITS'(ROW_LIMIT);
        end else begin
            hv = height_reg;
        end
        if (kernel_reg == '0) begin
            kv = KW'(1);
        end else if (32'(kernel_reg) > MK) begin
            kv = KW'(MK);
        end else begin
            kv = KW'(kernel_reg);
        end
        k1 = kv - KW'(1);
    end

    assign s_pad     = {{SB{1'b0}}, s_tdata[21:6]};
    assign s_val     = s_pad[SB-1:0];
    assign adv       = !m_tvalid_reg || m_tready;
    assign s_tready  = adv;
    assign acc       = s_tvalid && adv;
    assign acc_pix   = acc && (s_tuser == CMD_PIXEL);
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT
                                     || cfg_index == REG_KERNEL);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= CFG_BITS'(18);
            height_reg <= CFG_BITS'(18);
            kernel_reg <= KCFG_BITS'(3);
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                REG_KERNEL: kernel_reg <= cfg_data[KCFG_BITS-1:0];
                default: ;
            endcase
        end
    end

    // raster position and per-beat tag
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_wr) begin
            col_next = '0;
            row_next = '0;
        end else if (acc_pix) begin
            if (32'(col_reg) + 1 >= 32'(wv)) begin
                col_next = '0;
                if (32'(row_reg) + 1 >= 32'(hv)) begin
                    row_next = '0;
                end else begin
                    row_next = row_reg + POS_BITS'(1);
                end
            end else begin
                col_next = col_reg + CW'(1);
            end
        end

        p1_next.valid   = acc;
        p1_next.pix     = acc_pix;
        p1_next.ld      = acc && (s_tuser == CMD_LOAD) && col_reg == '0 && row_reg == '0
                          && 32'(s_tdata[5:0]) < NC;
        p1_next.idx     = s_tdata[5:0];
        p1_next.val     = s_val;
        p1_next.col     = col_reg;
        p1_next.tag.res = (32'(wv) >= 32'(kv)) && (32'(hv) >= 32'(kv))
                          && (32'(row_reg) >= 32'(k1)) && (32'(col_reg) >= 32'(k1));
        p1_next.tag.row = POS_BITS'(32'(row_reg) - 32'(k1));
        p1_next.tag.col = POS_BITS'(32'(col_reg) - 32'(k1));
        p1_next.tag.last = (32'(row_reg) == 32'(hv) - 1) && (32'(col_reg) == 32'(wv) - 1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_reg.valid <= 1'b0;
            p2_reg.valid <= 1'b0;
            fwd_reg      <= 1'b0;
        end else if (adv) begin
            p1_reg.valid <= p1_next.valid;
            p2_reg.valid <= p1_reg.valid;
            fwd_reg      <= p1_reg.valid && p1_reg.pix && acc_pix && (col_reg == p1_reg.col);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_reg.pix   <= p1_next.pix;
            p1_reg.ld    <= p1_next.ld;
            p1_reg.idx   <= p1_next.idx;
            p1_reg.val   <= p1_next.val;
            p1_reg.col   <= p1_next.col;
            p1_reg.tag   <= p1_next.tag;
            p2_reg.pix   <= p1_reg.pix;
            p2_reg.ld    <= p1_reg.ld;
            p2_reg.idx   <= p1_reg.idx;
            p2_reg.val   <= p1_reg.val;
            p2_reg.col   <= p1_reg.col;
            p2_reg.tag   <= p1_reg.tag;
            fwd_data_reg <= line_wd;
        end
    end

    // line store: one word per column holding the previous rows, newest lowest
    cv2d_ram #(
        .W (LR * SB),
        .D (MAX_WIDTH)
    ) u_line (
        .clk   (aclk),
        .we    (adv && p1_reg.valid && p1_reg.pix),
        .waddr (p1_reg.col),
        .wdata (line_wd),
        .re    (adv),
        .raddr (col_reg),
        .rdata (ram_q)
    );

    assign line_rd = fwd_reg ? fwd_data_reg : ram_q;

    always_comb begin
        for (int j = 0; j < LR; j++) begin
            old_ln[j] = line_rd[j*SB +: SB];
        end
        line_wd[SB-1:0] = p1_reg.val;
        for (int j = 1; j < LR; j++) begin
            line_wd[j*SB +: SB] = old_ln[j-1];
        end
        // new window column, oldest row first
        for (int m = 0; m < MK; m++) begin
            newcol[m] = '0;
            if (32'(m) == 32'(k1)) begin
                newcol[m] = p1_reg.val;
            end else begin
                for (int j = 0; j < LR; j++) begin
                    if (32'(j) == 32'(kv) - 2 - m) begin
                        newcol[m] = old_ln[j];
                    end
                end
            end
        end
    end

    // window cleared at reset so places outside the active kernel read as zero
    for (genvar m = 0; m < MK; m++) begin : g_row
        for (genvar n = 0; n < MK; n++) begin : g_col
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    win_reg[m][n] <= '0;
                end else if (adv && p1_reg.valid && p1_reg.pix) begin
                    if (n < MK - 1 && 32'(n) + 1 < 32'(kv)) begin
                        win_reg[m][n] <= win_reg[m][(n < MK - 1) ? n + 1 : n];
                    end else if (32'(n) == 32'(k1)) begin
                        win_reg[m][n] <= newcol[m];
                    end
                end
            end
        end
    end

    assign coef_wr.en  = p2_reg.valid && p2_reg.ld;
    assign coef_wr.idx = p2_reg.idx;

    cv2d_mac #(
        .MK (MK),
        .SB (SB),
        .KW (KW)
    ) u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .kv        (kv),
        .win       (win_reg),
        .in_valid  (p2_reg.valid && p2_reg.pix),
        .in_tag    (p2_reg.tag),
        .coef_wr   (coef_wr),
        .coef_val  (p2_reg.val),
        .out_valid (mac_valid),
        .out_tag   (mac_tag),
        .out_sum   (mac_sum)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= mac_valid && mac_tag.res;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sum_reg  <= mac_sum;
            otag_reg <= mac_tag;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, otag_reg.col, otag_reg.row, sum_reg};
    assign m_tlast  = otag_reg.last;

    a_fwd_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        fwd_reg |-> (p1_reg.valid && p1_reg.pix)) else $error("forward without pixel");
    a_reset_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !m_tvalid_reg) else $error("result after reset");
    a_p1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (!s_tready && p1_reg.valid) |=> p1_reg.valid) else $error("stage lost on stall");

endmodule

[tb/conv_checker.sv]
// ----------------------------------------------------------------------------
// conv_checker
// Watches the pixel, configuration and result channels of the convolution
// core, keeps its own copy of coefficients, line history and counters, and
// compares every result beat against the predicted sum and position.
// ----------------------------------------------------------------------------
module conv_checker
    import cv2d_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    input  logic                    s_tready,
    input  logic [23:0]             s_tdata,
    input  logic                    s_tuser,
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic [63:0]             m_tdata,
    input  logic                    m_tlast,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]     cfg_data,
    output int                      fail_count,
    output int                      pending
);

    localparam int MAXW = 1024;
    localparam int MAXK = 7;

    typedef struct packed {
        logic [SUM_BITS-1:0] sum;
        logic [POS_BITS-1:0] row;
        logic [POS_BITS-1:0] col;
        logic                last;
    } conv_result_t;

    logic signed [15:0] coefs [MAXK*MAXK];
    logic signed [15:0] history [MAXK-1][MAXW];
    logic signed [15:0] win [MAXK][MAXK];
    int unsigned col_pos, row_pos;
    logic [CFG_BITS-1:0]  width_reg, height_reg;
    logic [KCFG_BITS-1:0] ksize_reg;
    conv_result_t sums_due[$];

    assign pending = sums_due.size();

    function automatic int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    task automatic take_pixel(logic signed [15:0] px);
        int unsigned w, h, k;
        logic signed [15:0] fresh [MAXK];
        logic signed [63:0] acc;
        conv_result_t r;
        w = clip(width_reg, 1, MAXW);
        h = clip(height_reg, 1, ROW_LIMIT);
        k = clip(ksize_reg, 1, MAXK);
        for (int m = 0; m < k; m++)
            fresh[m] = (m == k - 1) ? px : history[k-2-m][col_pos];
        for (int m = MAXK - 2; m >= 1; m--)
            history[m][col_pos] = history[m-1][col_pos];
        history[0][col_pos] = px;
        for (int m = 0; m < k; m++) begin
            for (int n = 0; n + 1 < k; n++)
                win[m][n] = win[m][n+1];
            win[m][k-1] = fresh[m];
        end
        if (w >= k && h >= k && row_pos >= k - 1 && col_pos >= k - 1) begin
            acc = 0;
            for (int m = 0; m < k; m++)
                for (int n = 0; n < k; n++)
                    acc += 64'(win[m][n]) * 64'(coefs[m*k+n]);
            r.sum  = acc[SUM_BITS-1:0];
            r.row  = POS_BITS'(row_pos - (k - 1));
            r.col  = POS_BITS'(col_pos - (k - 1));
            r.last = (row_pos == h - 1 && col_pos == w - 1);
            sums_due.push_back(r);
        end
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h)
                row_pos = 0;
        end
    endtask

    always @(posedge aclk) begin
        conv_result_t got, want;
        if (!aresetn) begin
            foreach (coefs[i]) coefs[i] = '0;
            foreach (win[m, n]) win[m][n] = '0;
            col_pos = 0;
            row_pos = 0;
            width_reg  = 18;
            height_reg = 18;
            ksize_reg  = 3;
            sums_due.delete();
            fail_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_WIDTH:  width_reg  = cfg_data;
                    REG_HEIGHT: height_reg = cfg_data;
                    REG_KERNEL: ksize_reg  = cfg_data[KCFG_BITS-1:0];
                    default:    ;
                endcase
                if (cfg_index inside {REG_WIDTH, REG_HEIGHT, REG_KERNEL}) begin
                    col_pos = 0;
                    row_pos = 0;
                end
            end
            if (m_tvalid && m_tready) begin
                got = {m_tdata[36:0], m_tdata[46:37], m_tdata[56:47], m_tlast};
                if (sums_due.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, actual %h",
                             $time, got);
                    fail_count++;
                end else begin
                    want = sums_due.pop_front();
                    if (got.sum !== want.sum || got.row !== want.row ||
                        got.col !== want.col || got.last !== want.last) begin
                        $display("%0t: expected sum %0d row %0d col %0d last %b,",
                                 $time, $signed(want.sum), want.row, want.col, want.last);
                        $display("%0t: actual   sum %0d row %0d col %0d last %b",
                                 $time, $signed(got.sum), got.row, got.col, got.last);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == CMD_LOAD) begin
                    if (col_pos == 0 && row_pos == 0 && s_tdata[5:0] < MAXK*MAXK)
                        coefs[s_tdata[5:0]] = s_tdata[21:6];
                end else begin
                    take_pixel(s_tdata[21:6]);
                end
            end
        end
    end

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Drives coefficient loads, pixel frames and register writes into the
// convolution core under bursty input and a stalling receiver; the checker
// beside the core predicts and compares results.
// ----------------------------------------------------------------------------
module tb_top;
    import cv2d_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [CFG_BITS-1:0]     cfg_data;
    int fail_count, pending;
    int idle_cycles = 0;
    int burst_left;
    int sent;

    valid_conv2d_stream_core dut (.*);

    conv_checker chk (.*);

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // receiver stall pattern: periods of readiness, stalls and long free runs
    initial begin
        int mode;
        m_tready = 1'b1;
        forever begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(1, 40)) begin
                @(negedge aclk);
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    // watchdog on cycles with no accepted beat
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("valid_conv2d_stream_core: mismatch");
            $finish;
        end
    end

    task automatic send_beat(logic cmd, logic [5:0] idx, logic [15:0] val);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
            burst_left = $urandom_range(1, 30);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {2'b00, val, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        burst_left--;
        sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (12) @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_shape(int w, int h, int k);
        drain();
        write_reg(REG_WIDTH, CFG_BITS'(w));
        write_reg(REG_HEIGHT, CFG_BITS'(h));
        write_reg(REG_KERNEL, CFG_BITS'(k));
    endtask

    // k*k coefficients loaded between frames, then full frames of random pixels
    task automatic run_frames(int k, int w, int h, int frames, bit extreme);
        int kk;
        kk = (k == 0) ? 1 : k;
        for (int f = 0; f < frames; f++) begin
            for (int i = 0; i < kk * kk; i++)
                send_beat(CMD_LOAD, 6'(i),
                          extreme ? (i % 2 ? 16'h8000 : 16'h7fff) : 16'($urandom));
            // occasional loads that must be ignored (bad index)
            if ($urandom_range(0, 3) == 0)
                send_beat(CMD_LOAD, 6'($urandom_range(49, 63)), 16'($urandom));
            for (int p = 0; p < (w == 0 ? 1 : w) * (h == 0 ? 1 : h); p++) begin
                if (p == 1 && $urandom_range(0, 4) == 0)
                    send_beat(CMD_LOAD, 6'($urandom_range(0, 48)), 16'($urandom));
                send_beat(CMD_PIXEL, 6'($urandom), extreme ? (p % 2 ? 16'h7fff : 16'h8000)
                                                           : 16'($urandom));
            end
        end
    endtask

    initial begin
        int k, w, h;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = CMD_PIXEL;
        cfg_valid = 1'b0;
        cfg_index = REG_WIDTH;
        cfg_data  = '0;
        burst_left = 0;
        sent = 0;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed: extreme values, kernel 3 on a small 4x3 frame
        set_shape(4, 3, 3);
        run_frames(3, 4, 3, 1, 1'b1);
        // image smaller than kernel, zero registers acting as one, kernel 7
        set_shape(2, 5, 3);
        run_frames(3, 2, 5, 1, 1'b0);
        set_shape(0, 0, 0);
        run_frames(1, 1, 1, 1, 1'b0);
        set_shape(7, 7, 7);
        run_frames(7, 7, 7, 1, 1'b1);
        // oversized registers saturate
        set_shape(2047, 1, 1);
        for (int i = 0; i < 20; i++)
            send_beat(CMD_PIXEL, 6'($urandom), 16'($urandom));
        set_shape(1, 2047, 1);
        for (int i = 0; i < 10; i++)
            send_beat(CMD_PIXEL, 6'($urandom), 16'($urandom));

        while (sent < 800) begin
            k = $urandom_range(0, 7);
            w = $urandom_range(0, 10);
            h = $urandom_range(0, 9);
            if ($urandom_range(0, 5) == 0)
                w = $urandom_range(0, 1);
            set_shape(w, h, k);
            run_frames(k, w, h, $urandom_range(1, 2), 1'b0);
            // partial frame broken by the next register write
            if ($urandom_range(0, 3) == 0)
                for (int i = 0; i < $urandom_range(1, 12); i++)
                    send_beat(CMD_PIXEL, 6'($urandom), 16'($urandom));
        end

        drain();
        if (fail_count == 0)
            $display("valid_conv2d_stream_core: match");
        else
            $display("valid_conv2d_stream_core: mismatch");
        $finish;
    end

endmodule
